// ----- hdl/c_string_unescaper_assert.svh -----
// ----------------------------------------------------------------------------
// c_string_unescaper assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef C_STRING_UNESCAPER_ASSERT_SVH
`define C_STRING_UNESCAPER_ASSERT_SVH

`ifndef SYNTHESIS
// Implication property checked on every clock edge outside reset
`define CSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Property checked in the cycle after the antecedent
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, constants and the escape letter table of the unescaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cse_pkg;

    // Parse mode of the decoder
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_OCT1  = 2'd2,
        MODE_OCT2  = 2'd3
    } mode_t;

    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    // Output queue depth; a transaction may push two results
    localparam int QDEPTH = 4;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } res_t;

    // Decoder outputs for one input transaction
    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] n;
        mode_t      mode_next;
        logic [7:0] oct_next;
    } dec_t;

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
    endfunction

    // Escape letters to control codes; other bytes stay as they are
    function automatic logic [7:0] escape_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h61:   r = 8'h07;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h76:   r = 8'h0B;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/cse_in_if.sv -----
// ----------------------------------------------------------------------------
// cse_in_if
// Input channel: one escaped text byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- hdl/cse_out_if.sv -----
// ----------------------------------------------------------------------------
// cse_out_if
// Output channel: one unescaped byte or end marker per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    output ready);
endinterface

// ----- hdl/cse_decode.sv -----
// ----------------------------------------------------------------------------
// cse_decode
// Next-state and result logic for one input byte of escaped text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_decode
    import cse_pkg::*;
(
    input  mode_t      mode,
    input  logic [7:0] oct,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output dec_t       dec
);

    always_comb
    begin
        logic [7:0] d0;
        logic [7:0] d1;
        logic [1:0] n;
        mode_t      m;
        logic [7:0] v;
        logic [7:0] oct_shift;

        d0        = '0;
        d1        = '0;
        n         = 2'd0;
        m         = mode;
        v         = oct;
        oct_shift = {oct[4:0], in_byte[2:0]};

        // byte handling per mode
        case (mode)
            MODE_PLAIN:
            begin
                if (in_byte == CHAR_BSL)
                begin
                    m = MODE_ESC;
                end
                else
                begin
                    d0 = in_byte;
                    n  = 2'd1;
                    m  = MODE_PLAIN;
                end
            end
            MODE_ESC:
            begin
                if (in_byte >= CHAR_ZERO && in_byte <= CHAR_THREE)
                begin
                    v = {5'd0, in_byte[2:0]};
                    m = MODE_OCT1;
                end
                else
                begin
                    d0 = escape_map(in_byte);
                    n  = 2'd1;
                    m  = MODE_PLAIN;
                end
            end
            MODE_OCT1, MODE_OCT2:
            begin
                if (is_octal(in_byte))
                begin
                    v = oct_shift;
                    if (mode == MODE_OCT1)
                    begin
                        m = MODE_OCT2;
                    end
                    else
                    begin
                        d0 = oct_shift;
                        n  = 2'd1;
                        m  = MODE_PLAIN;
                    end
                end
                else
                begin
                    // pending value first, then the byte as plain text
                    d0 = oct;
                    n  = 2'd1;
                    if (in_byte == CHAR_BSL)
                    begin
                        m = MODE_ESC;
                    end
                    else
                    begin
                        d1 = in_byte;
                        n  = 2'd2;
                        m  = MODE_PLAIN;
                    end
                end
            end
            default:
            begin
                m = MODE_PLAIN;
            end
        endcase

        dec.r0    = '{out_byte: d0, has_byte: 1'b1, out_last: 1'b0};
        dec.r1    = '{out_byte: d1, has_byte: 1'b1, out_last: 1'b0};
        dec.n     = n;
        dec.mode_next = m;
        dec.oct_next  = v;

        // end of text: flush pending value, drop lone backslash
        if (in_last)
        begin
            if (m == MODE_OCT1 || m == MODE_OCT2)
            begin
                if (n == 2'd0)
                begin
                    dec.r0.out_byte = v;
                end
                else
                begin
                    dec.r1.out_byte = v;
                end
                n = n + 2'd1;
            end
            if (n == 2'd0)
            begin
                dec.r0 = '{out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b0};
                n      = 2'd1;
            end
            if (n == 2'd1)
            begin
                dec.r0.out_last = 1'b1;
            end
            else
            begin
                dec.r1.out_last = 1'b1;
            end
            dec.n         = n;
            dec.mode_next = MODE_PLAIN;
            dec.oct_next  = '0;
        end
    end

endmodule

// ----- hdl/c_string_unescaper.sv -----
// ----------------------------------------------------------------------------
// c_string_unescaper
// Streaming decoder for C backslash escapes with octal values.
// ----------------------------------------------------------------------------
// Usage:
//   din carries escaped text, one byte per transaction, with in_last on the
//   final byte of a text. dout carries unescaped bytes; has_byte is 0 only
//   on a bare end marker, and out_last flags the final result of a text.
//   Each input transaction is decoded in the cycle it is accepted and its
//   one or two results are written to a four-entry output queue, so the
//   first result is on dout in the cycle after acceptance if the queue was empty.
//   Throughput: one input byte per cycle while each byte yields at most one
//   result and dout.ready stays high; a byte that yields two results adds
//   load beyond the one-result-per-cycle output port.
//   din.ready is high while the queue has room for two results, so input
//   keeps flowing while a result waits on a stalled receiver; a long stall
//   leaves fewer than two free entries and then holds din.ready low.
//   Reset empties the queue and returns the decoder to plain text mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "c_string_unescaper_assert.svh"

module c_string_unescaper
    import cse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    cse_in_if.sink   din,
    cse_out_if.source dout
);

    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    mode_t             mode_reg;
    logic [7:0]        oct_reg;
    res_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    dec_t              dec;
    logic              in_acc;
    logic              out_acc;
    logic [QCNT_W-1:0] push_n;
    logic [QPTR_W-1:0] wr_plus1;

    // decode logic
    cse_decode u_decode (
        .mode    (mode_reg),
        .oct     (oct_reg),
        .in_byte (din.in_byte),
        .in_last (din.in_last),
        .dec     (dec)
    );

    // handshakes
    assign din.ready = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign in_acc    = din.valid && din.ready;
    assign out_acc   = dout.valid && dout.ready;
    assign push_n    = in_acc ? QCNT_W'(dec.n) : '0;
    assign wr_plus1  = wr_reg + QPTR_W'(1);
    assign cnt_next  = cnt_reg + push_n - QCNT_W'(out_acc);

    // output side
    assign dout.valid    = (cnt_reg != '0);
    assign dout.out_byte = q_reg[rd_reg].out_byte;
    assign dout.has_byte = q_reg[rd_reg].has_byte;
    assign dout.out_last = q_reg[rd_reg].out_last;

    // parse state and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            oct_reg  <= '0;
            wr_reg   <= '0;
            rd_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                mode_reg <= dec.mode_next;
                oct_reg  <= dec.oct_next;
                wr_reg   <= wr_reg + QPTR_W'(dec.n);
            end
            if (out_acc)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_acc && dec.n != 2'd0)
        begin
            q_reg[wr_reg] <= dec.r0;
        end
        if (in_acc && dec.n == 2'd2)
        begin
            q_reg[wr_plus1] <= dec.r1;
        end
    end

    // checks
    `CSE_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= QCNT_W'(QDEPTH))
    `CSE_ASSERT_IMPL(a_push_nonzero, clk, rst_n, in_acc && din.in_last, dec.n != 2'd0)
    `CSE_ASSERT_NEXT(a_last_clears, clk, rst_n, in_acc && din.in_last,
                     mode_reg == MODE_PLAIN && oct_reg == 8'd0)
    `CSE_ASSERT_NEXT(a_cnt_track, clk, rst_n, 1'b1,
                     QPTR_W'(cnt_reg) == wr_reg - rd_reg)

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for c_string_unescaper. Escaped texts are sent byte
// by byte with random bursts and gaps, and an in-house decoder computes the
// unescaped bytes each transaction must produce. Every output transaction is
// compared field by field with the oldest pending byte while the receiver
// runs free, holds off for a long spell, or stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import cse_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    cse_in_if  din_if ();
    cse_out_if dout_if ();

    c_string_unescaper u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    // Unescaped bytes still owed by the block, oldest first
    res_t       unescaped_q[$];
    // Escaped text being assembled before it is sent
    logic [7:0] text_buf[$];

    // Decoder state mirrored from the block
    mode_t      esc_mode;
    logic [7:0] esc_val;

    string      esc_letters = "abfnrtv";
    int         items_sent  = 0;
    int         fail_cnt    = 0;

    // Sender pacing
    bit         tx_bursty   = 1'b1;
    int         burst_left  = 0;

    // Receiver pacing
    bit         rx_free     = 1'b0;
    int         rx_hold_len = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    int         rx_age      = 0;

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------------
    task automatic push_char(input logic [7:0] b);
        res_t r;
        r.out_byte = b;
        r.has_byte = 1'b1;
        r.out_last = 1'b0;
        unescaped_q.push_back(r);
    endtask

    // Byte seen in plain text: backslash opens an escape, anything else passes
    task automatic plain_char(input logic [7:0] b);
        if (b == CHAR_BSL)
        begin
            esc_mode = MODE_ESC;
        end
        else
        begin
            esc_mode = MODE_PLAIN;
            push_char(b);
        end
    endtask

    task automatic unescape_byte(input logic [7:0] b, input logic last);
        int         n0;
        logic       oct_digit;
        logic [7:0] code;
        res_t       tail;
        n0        = unescaped_q.size();
        oct_digit = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
        case (esc_mode)
            MODE_PLAIN:
            begin
                plain_char(b);
            end
            MODE_ESC:
            begin
                if (b >= CHAR_ZERO && b <= CHAR_THREE)
                begin
                    esc_val  = {5'd0, b[2:0]};
                    esc_mode = MODE_OCT1;
                end
                else
                begin
                    case (b)
                        "a":     code = 8'h07;  // bell
                        "b":     code = 8'h08;  // backspace
                        "f":     code = 8'h0C;  // form feed
                        "n":     code = 8'h0A;  // line feed
                        "r":     code = 8'h0D;  // carriage return
                        "t":     code = 8'h09;  // tab
                        "v":     code = 8'h0B;  // vertical tab
                        default: code = b;
                    endcase
                    push_char(code);
                    esc_mode = MODE_PLAIN;
                end
            end
            MODE_OCT1:
            begin
                if (oct_digit)
                begin
                    esc_val  = {esc_val[4:0], b[2:0]};
                    esc_mode = MODE_OCT2;
                end
                else
                begin
                    push_char(esc_val);
                    plain_char(b);
                end
            end
            default:
            begin
                if (oct_digit)
                begin
                    esc_val = {esc_val[4:0], b[2:0]};
                    push_char(esc_val);
                    esc_mode = MODE_PLAIN;
                end
                else
                begin
                    push_char(esc_val);
                    plain_char(b);
                end
            end
        endcase

        // End of text: flush a pending value, drop a lone backslash
        if (last)
        begin
            if (esc_mode == MODE_OCT1 || esc_mode == MODE_OCT2)
                push_char(esc_val);
            if (unescaped_q.size() == n0)
            begin
                tail.out_byte = 8'h00;
                tail.has_byte = 1'b0;
                tail.out_last = 1'b1;
                unescaped_q.push_back(tail);
            end
            else
            begin
                tail = unescaped_q.pop_back();
                tail.out_last = 1'b1;
                unescaped_q.push_back(tail);
            end
            esc_mode = MODE_PLAIN;
            esc_val  = 8'h00;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (tx_bursty && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                din_if.valid   <= 1'b0;
                din_if.in_byte <= 8'($urandom);
                din_if.in_last <= 1'($urandom);
            end
        end
        @(negedge clk);
        din_if.valid   <= 1'b1;
        din_if.in_byte <= b;
        din_if.in_last <= last;
        do
            @(posedge clk);
        while (!din_if.ready);
        unescape_byte(b, last);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
    endtask

    // Send the assembled text, in_last on its final byte
    task automatic send_text_buf();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // One random fragment of escaped text
    task automatic add_piece();
        int kind;
        int k;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
            begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
            3:
            begin
                text_buf.push_back(CHAR_BSL);
                text_buf.push_back(esc_letters[$urandom_range(0, 6)]);
            end
            4, 5:
            begin
                // octal escape, sometimes followed by a plain digit
                text_buf.push_back(CHAR_BSL);
                text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 3)));
                k = $urandom_range(0, 3);
                repeat (k)
                    text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 7)));
            end
            6:
            begin
                text_buf.push_back(CHAR_BSL);
                text_buf.push_back(CHAR_ZERO + 8'($urandom_range(4, 9)));
            end
            7:
            begin
                text_buf.push_back(CHAR_BSL);
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
            8:
            begin
                text_buf.push_back(CHAR_BSL);
                text_buf.push_back(CHAR_BSL);
            end
            default:
            begin
                text_buf.push_back(CHAR_BSL);
            end
        endcase
    endtask

    // Mostly well-formed texts, some raw noise
    task automatic build_random_text();
        int n;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 10);
            repeat (n)
                text_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                add_piece();
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (unescaped_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: long hold when requested, else free or patterned stalls
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold_len > 0)
        begin
            dout_if.ready <= 1'b0;
            rx_hold_len--;
        end
        else if (rx_free)
        begin
            dout_if.ready <= 1'b1;
        end
        else
        begin
            if (rx_age == 0)
            begin
                rx_pattern = 16'($urandom_range(1, 16'hFFFF));
                rx_age     = 32;
            end
            dout_if.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            rx_age--;
        end
    end

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_result
        res_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (unescaped_q.size() == 0)
            begin
                $error("unexpected transaction: out_byte=%h has_byte=%b out_last=%b",
                       dout_if.out_byte, dout_if.has_byte, dout_if.out_last);
                fail_cnt++;
            end
            else
            begin
                want = unescaped_q.pop_front();
                if (dout_if.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, dout_if.out_byte);
                    fail_cnt++;
                end
                if (dout_if.has_byte !== want.has_byte)
                begin
                    $error("has_byte: expected %b, got %b", want.has_byte, dout_if.has_byte);
                    fail_cnt++;
                end
                if (dout_if.out_last !== want.out_last)
                begin
                    $error("out_last: expected %b, got %b", want.out_last, dout_if.out_last);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero byte, every letter escape, octal extremes, flushes and empty end
    task automatic test_directed_escapes();
        tx_bursty = 1'b1;
        rx_free   = 1'b0;
        text_buf.delete();
        text_buf.push_back(8'h00);
        push_str("\\a\\b\\f\\n\\r\\t\\v");
        send_text_buf();
        // \377 then an octal zero flushed by the end of text
        push_str("\\377\\0");
        send_text_buf();
        // lone backslash at the end gives a bare end marker
        push_str("\\");
        send_text_buf();
        // digit above three is literal, short octal flushed at the end
        push_str("\\9\\12");
        send_text_buf();
        text_buf.push_back(8'hFF);
        send_text_buf();
    endtask

    task automatic test_random_texts(input int n_items);
        int stop_at;
        tx_bursty = 1'b1;
        rx_free   = 1'b0;
        stop_at   = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            build_random_text();
            send_text_buf();
        end
    endtask

    // Receiver holds off while the sender keeps going, then a full drain
    task automatic test_output_backpressure();
        int stop_at;
        tx_bursty = 1'b0;
        rx_free   = 1'b1;
        repeat (2)
        begin
            rx_hold_len = 60;
            stop_at     = items_sent + 60;
            while (items_sent < stop_at)
            begin
                build_random_text();
                send_text_buf();
            end
            wait_all_results();
        end
    endtask

    // No idling on either side
    task automatic test_streaming(input int n_items);
        int stop_at;
        tx_bursty = 1'b0;
        rx_free   = 1'b1;
        stop_at   = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            build_random_text();
            send_text_buf();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        din_if.valid   = 1'b0;
        din_if.in_byte = 8'h00;
        din_if.in_last = 1'b0;
        dout_if.ready  = 1'b0;
        esc_mode       = MODE_PLAIN;
        esc_val        = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_escapes();
        test_random_texts(1100);
        test_output_backpressure();
        test_streaming(350);
        test_random_texts(50);

        wait_all_results();
        repeat (10) @(posedge clk);
        if (fail_cnt == 0 && unescaped_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
